// ===== hdl/ats_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Alias sampler package: sequencer state type, command kinds and fixed-point width.
package ats_pkg;

  localparam int FRAC_BITS = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PAIR_IX,
    ST_PAIR_RD,
    ST_PAIR_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } ats_state_t;

endpackage : ats_pkg
`default_nettype wire

// ===== hdl/alias_table_sampler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Walker alias sampler: load, table build and draw sequencer with its memories.
//
// channel    | signals                          | direction
// command    | start, kind, probability, uniform | in, taken when start & !busy
// config     | cfg_we, cfg_data                  | in, written when cfg_we
// result     | done, category                    | out, one-cycle strobe
//
// A load is taken while idle. The last load starts the table build: each alias is
// first set to itself, then each pairing step does a list read, a mass memory read
// and a write back, and a last list check closes the build. A draw runs through a
// multiply, a memory read and a compare. rst is synchronous; memories
// hold no reset. The receiver cannot stall; busy holds off new commands while
// a build or draw is under way.
module alias_table_sampler_top #(
  parameter int MAX_CATEGORIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [0:0]  kind,
  input  wire logic [31:0] probability,
  input  wire logic [31:0] uniform,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_data,
  output logic             done,
  output logic [7:0]       category
);
  import ats_pkg::*;

  localparam int IW = $clog2(MAX_CATEGORIES);
  localparam int CW = IW + 1;
  localparam int MW = FRAC_BITS + CW;
  localparam logic [MW-1:0] ONE = MW'(1) << FRAC_BITS;

  // memories
  logic [MW-1:0] mass_mem  [MAX_CATEGORIES];
  logic [IW-1:0] alias_mem [MAX_CATEGORIES];
  logic [IW-1:0] order_mem [MAX_CATEGORIES];

  ats_state_t state, state_next;
  logic [CW-1:0] count, small_tail, large_head, load_count, k;
  logic          ready;
  logic [IW-1:0] pi, pj;
  logic [MW-1:0] mi, mj;
  logic [MW-1:0] r;
  logic [IW-1:0] slot;
  logic [FRAC_BITS-1:0] frac;
  logic [MW-1:0] rd_mass;
  logic [IW-1:0] rd_alias;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  logic [CW-1:0] cfg_clamp;
  always_comb begin
    cfg_clamp = CW'(cfg_data);
    if (cfg_data == 9'd0) cfg_clamp = CW'(1);
    else if (int'(cfg_data) > MAX_CATEGORIES) cfg_clamp = CW'(MAX_CATEGORIES);
  end

  logic [MW-1:0] q;
  assign q = MW'(probability) * MW'(count);

  logic [MW-1:0] newmj;
  assign newmj = mj + mi - ONE;

  // list positions for a load, restarted when a table is already built
  logic [CW-1:0] load_st, load_lh, load_lc;
  logic          load_ok, load_small, load_last;
  always_comb begin
    load_st = ready ? '0 : small_tail;
    load_lh = ready ? count : large_head;
    load_lc = ready ? '0 : load_count;
  end
  assign load_ok    = accept && (kind == KIND_LOAD) && (load_lc < count) &&
                      (load_st < load_lh);
  assign load_small = (q < ONE);
  assign load_last  = load_ok && (load_lc + CW'(1) == count);

  // pairing continuation check at the start of each step
  logic pair_go;
  assign pair_go = (small_tail != '0) && (large_head < count) &&
                   (k + CW'(1) < count) && (k < large_head);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_DRAW && ready) state_next = ST_DRAW_RD;
        else if (load_last) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (k == count - CW'(1)) state_next = ST_PAIR_IX;
      end
      ST_PAIR_IX:  state_next = pair_go ? ST_PAIR_RD : ST_IDLE;
      ST_PAIR_RD:  state_next = ST_PAIR_WR;
      ST_PAIR_WR:  state_next = ST_PAIR_IX;
      ST_DRAW_RD:  state_next = ST_DRAW_OUT;
      ST_DRAW_OUT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= CW'(1);
      small_tail <= '0;
      large_head <= CW'(1);
      load_count <= '0;
      ready      <= 1'b0;
      k          <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        count      <= cfg_clamp;
        small_tail <= '0;
        large_head <= cfg_clamp;
        load_count <= '0;
        ready      <= 1'b0;
      end else begin
        state <= state_next;
        unique case (state)
          ST_IDLE: begin
            if (accept && kind == KIND_LOAD) begin
              ready      <= 1'b0;
              small_tail <= (load_ok && load_small) ? load_st + CW'(1) : load_st;
              large_head <= (load_ok && !load_small) ? load_lh - CW'(1) : load_lh;
              load_count <= load_ok ? load_lc + CW'(1) : load_lc;
              if (load_last) k <= '0;
            end
          end
          ST_INIT: begin
            k <= (k == count - CW'(1)) ? '0 : k + CW'(1);
          end
          ST_PAIR_IX: begin
            if (!pair_go) ready <= 1'b1;
          end
          ST_PAIR_WR: begin
            if (newmj < ONE) large_head <= large_head + CW'(1);
            k <= k + CW'(1);
          end
          ST_DRAW_OUT: done <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // order list and indices for pairing
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (load_small) order_mem[load_st[IW-1:0]] <= load_lc[IW-1:0];
      else order_mem[IW'(load_lh - CW'(1))] <= load_lc[IW-1:0];
    end
  end

  // pairing reads of both list heads
  always_ff @(posedge clk) begin
    pi <= order_mem[k[IW-1:0]];
    pj <= order_mem[large_head[IW-1:0]];
  end

  // draw slot computation
  always_ff @(posedge clk) begin
    if (accept) begin
      r <= MW'(uniform) * MW'(count);
    end
  end
  always_comb begin
    if ((r >> FRAC_BITS) >= MW'(count)) begin
      slot = IW'(count - CW'(1));
      frac = '1;
    end else begin
      slot = IW'(r >> FRAC_BITS);
      frac = r[FRAC_BITS-1:0];
    end
  end

  // mass memory: load write, pairing write back, pairing and draw reads
  logic [IW-1:0] rd_addr_a;
  always_comb begin
    if (state == ST_DRAW_RD) rd_addr_a = slot;
    else rd_addr_a = pi;
  end
  always_ff @(posedge clk) begin
    if (load_ok)
      mass_mem[load_lc[IW-1:0]] <= q;
    else if (state == ST_PAIR_WR)
      mass_mem[pj] <= newmj;
    mi      <= mass_mem[rd_addr_a];
    mj      <= mass_mem[pj];
  end
  assign rd_mass = mi;

  // alias memory: self init, pairing writes, draw read
  always_ff @(posedge clk) begin
    if (state == ST_INIT) alias_mem[k[IW-1:0]] <= k[IW-1:0];
    else if (state == ST_PAIR_WR) alias_mem[pi] <= pj;
    rd_alias <= alias_mem[slot];
  end

  // result
  logic [FRAC_BITS-1:0] frac_q;
  logic [IW-1:0]        slot_q;
  always_ff @(posedge clk) begin
    if (state == ST_DRAW_RD) begin
      frac_q <= frac;
      slot_q <= slot;
    end
  end
  logic [IW-1:0] pick;
  assign pick = (MW'(frac_q) < rd_mass) ? slot_q : rd_alias;
  always_ff @(posedge clk) begin
    if (state == ST_DRAW_OUT) category <= 8'(pick);
  end

  // draws only leave once the table is built
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> ready) else $error("result without table");
  a_busy_draw: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW_OUT |=> done) else $error("draw lost");
  a_lists: assert property (@(posedge clk) disable iff (rst)
    small_tail <= large_head) else $error("lists overlap");
endmodule : alias_table_sampler_top
`default_nettype wire
